/* design/lcu_pkg.sv */
// shared types, codes, reset values and elaboration-time table functions
package lcu_pkg;

  localparam int CELL_W = 16;
  localparam int GEN_W  = 32;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 20;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_COMMIT = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  localparam logic [CFG_IW-1:0] CFG_ROWS  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_COLS  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MU    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_IVS   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DT    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_THR   = 3'd5;

  localparam logic [6:0]  RST_ROWS = 7'd64;
  localparam logic [6:0]  RST_COLS = 7'd64;
  localparam logic [15:0] RST_MU   = 16'd9830;
  localparam logic [19:0] RST_IVS  = 20'd71111;
  localparam logic [15:0] RST_DT   = 16'd6554;
  localparam logic [15:0] RST_THR  = 16'd6554;

  // per-entry ratio of the exp table, q32, from a truncated taylor series
  function automatic logic [63:0] exp_ratio(logic [63:0] t);
    logic [63:0] term;
    logic [63:0] c;
    term = 64'd1 << 32;
    c    = 64'd1 << 32;
    term = ((term * t) >> 32) / 1; c = c - term;
    term = ((term * t) >> 32) / 2; c = c + term;
    term = ((term * t) >> 32) / 3; c = c - term;
    term = ((term * t) >> 32) / 4; c = c + term;
    term = ((term * t) >> 32) / 5; c = c - term;
    term = ((term * t) >> 32) / 6; c = c + term;
    term = ((term * t) >> 32) / 7; c = c - term;
    term = ((term * t) >> 32) / 8; c = c + term;
    return c;
  endfunction

  // exp table entry i, q16 rounded
  function automatic logic [16:0] exp_entry(int i, logic [63:0] c);
    logic [63:0] r;
    r = 64'd1 << 32;
    for (int k = 0; k < i; k++) begin
      r = (r * c) >> 32;
    end
    return 17'((r + 64'd32768) >> 16);
  endfunction

  function automatic logic [16:0] exp_lookup_c(logic [63:0] u, int depth, logic [63:0] c);
    logic [63:0] idx;
    if (u >= (64'd1 << 40)) return 17'd0;
    idx = (u * 64'(depth)) >> 19;
    if (idx >= 64'(depth)) return 17'd0;
    return exp_entry(int'(idx), c);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    rem  = v;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 6-bit value modulo a 7-bit count of at least one, restoring steps
  function automatic logic [5:0] umod6(logic [5:0] v, logic [6:0] n);
    logic [7:0] rem;
    rem = 8'd0;
    for (int i = 5; i >= 0; i--) begin
      rem = {rem[6:0], v[i]};
      if (rem >= {1'b0, n}) rem = rem - {1'b0, n};
    end
    return rem[5:0];
  endfunction

endpackage

/* design/lcu_ram.sv */
// single-port cell memory with registered read
module lcu_ram #(
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  logic [lcu_pkg::CELL_W-1:0] wdata,
  output logic [lcu_pkg::CELL_W-1:0] rdata
);
  import lcu_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/lcu_growth.sv */
// potential division, growth lookup and clamped increment for one cell
module lcu_growth #(
  parameter int          EXP_TABLE_DEPTH = 256,
  parameter int          ACC_W           = 43,
  parameter logic [63:0] K_TOTAL         = 64'd1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ACC_W-1:0]           acc,
  input  logic [lcu_pkg::CELL_W-1:0] center_value,
  input  logic [15:0]                mu,
  input  logic [19:0]                ivs,
  input  logic [15:0]                dt,
  output logic                       done,
  output logic [lcu_pkg::CELL_W-1:0] result
);
  import lcu_pkg::*;

  // floor(2^s / k) + 1, rounded-up reciprocal of the kernel total
  function automatic logic [127:0] recip_up(int s, logic [63:0] k);
    logic [127:0] q;
    logic [64:0]  rem;
    q   = '0;
    rem = '0;
    if (k == 64'd0) return '0;
    for (int i = s; i >= 0; i--) begin
      rem = {rem[63:0], (i == s)};
      if (rem >= {1'b0, k}) begin
        rem  = rem - {1'b0, k};
        q[i] = 1'b1;
      end
    end
    return q + 128'd1;
  endfunction

  localparam int          EW      = $clog2(EXP_TABLE_DEPTH);
  localparam logic [63:0] ExpStep = (64'd8 << 32) / EXP_TABLE_DEPTH;
  localparam logic [63:0] ExpC    = exp_ratio(ExpStep);

  // acc < K_TOTAL * 2^16, so a shift of 2*KW+16 keeps the quotient exact
  localparam int KW  = $clog2(K_TOTAL + 64'd1);
  localparam int RS  = 2 * KW + 16;
  localparam int MW  = KW + 18;
  localparam int AH  = (ACC_W + 1) / 2;
  localparam int MH  = (MW + 1) / 2;
  localparam int AW2 = 2 * AH;
  localparam int MW2 = 2 * MH;
  localparam int PPW = AH + MH;
  localparam int PW  = AW2 + MW2;
  localparam logic [127:0]   RecipFull = recip_up(RS, K_TOTAL);
  localparam logic [MW2-1:0] Recip     = MW2'(RecipFull);

  typedef enum logic [2:0] {G_IDLE, G_DIV, G_SQ, G_MUL, G_IDX, G_MAG, G_FIN} gstate_t;

  gstate_t           state_r;
  logic [AW2-1:0]    a_r;
  logic [PW-1:0]     prod_r;
  logic [1:0]        cnt_r;
  logic [CELL_W-1:0] v0_r;
  logic [31:0]       dd_r;
  logic [30:0]       u_r;
  logic [16:0]       e_r;
  logic [16:0]       mag_r;
  logic              neg_r;

  logic [16:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_exp
    assign exp_rom[i] = exp_entry(i, ExpC);
  end

  logic [AH-1:0]      a_part;
  logic [MH-1:0]      m_part;
  logic [PPW-1:0]     pp;
  logic [PW-1:0]      pp_sh;
  logic [15:0]        quo;
  logic signed [16:0] diff;
  logic signed [33:0] sq;
  logic [51:0]        uprod;
  logic [43:0]        scaled;
  logic [24:0]        idx_full;
  logic [16:0]        absg;
  logic               gneg;
  logic [32:0]        mprod;
  logic [17:0]        sum;

  always_comb begin
    // one partial product of acc times the reciprocal per cycle
    a_part   = cnt_r[1] ? a_r[AW2-1:AH] : a_r[AH-1:0];
    m_part   = cnt_r[0] ? Recip[MW2-1:MH] : Recip[MH-1:0];
    pp       = PPW'(a_part) * PPW'(m_part);
    pp_sh    = PW'(pp) << ((cnt_r[1] ? AH : 0) + (cnt_r[0] ? MH : 0));
    quo      = prod_r[RS +: 16];
    diff     = $signed({1'b0, quo}) - $signed({1'b0, mu});
    sq       = diff * diff;
    uprod    = 52'(dd_r) * 52'(ivs);
    scaled   = 44'(u_r) * 44'(EXP_TABLE_DEPTH);
    idx_full = scaled[43:19];
    gneg     = e_r < 17'd32768;
    absg     = gneg ? (17'd65536 - {e_r[15:0], 1'b0}) : ({e_r[15:0], 1'b0} - 17'd65536);
    mprod    = 33'(absg) * 33'(dt);
    sum      = 18'(v0_r) + 18'(mag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        G_IDLE: begin
          if (start) begin
            a_r     <= AW2'(acc);
            prod_r  <= '0;
            cnt_r   <= '0;
            v0_r    <= center_value;
            state_r <= G_DIV;
          end
        end
        G_DIV: begin
          prod_r <= prod_r + pp_sh;
          cnt_r  <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_r <= G_SQ;
        end
        G_SQ: begin
          dd_r    <= sq[31:0];
          state_r <= G_MUL;
        end
        G_MUL: begin
          u_r     <= uprod[51:21];
          state_r <= G_IDX;
        end
        G_IDX: begin
          e_r     <= (idx_full < 25'(EXP_TABLE_DEPTH)) ? exp_rom[idx_full[EW-1:0]] : 17'd0;
          state_r <= G_MAG;
        end
        G_MAG: begin
          mag_r   <= mprod[32:16];
          neg_r   <= gneg;
          state_r <= G_FIN;
        end
        G_FIN: begin
          if (neg_r) begin
            result <= (17'(v0_r) >= mag_r) ? CELL_W'(17'(v0_r) - mag_r) : '0;
          end else begin
            result <= (sum > 18'd65535) ? 16'hFFFF : sum[15:0];
          end
          done    <= 1'b1;
          state_r <= G_IDLE;
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

endmodule

/* design/lenia_cell_update.sv */
// lenia cell update engine: two cell banks, ring-kernel scan and growth step
// load and commit pass from accept through dispatch to emit; read also passes a read state
// update time is set by the one-read-per-cycle neighbourhood scan of the single-port live bank
// one transaction in flight; the next is accepted once the result registers, later if it waits
// after reset both banks are swept to zero before in_ready rises
module lenia_cell_update #(
  parameter int MAX_ROWS        = 64,
  parameter int MAX_COLS        = 64,
  parameter int KERNEL_RADIUS   = 5,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic [5:0]                 in_row,
  input  logic [5:0]                 in_col,
  input  logic [lcu_pkg::CELL_W-1:0] in_load_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lcu_pkg::CELL_W-1:0] out_cell_value,
  output logic                       out_alive,
  output logic [7:0]                 out_age,
  output logic [lcu_pkg::GEN_W-1:0]  out_generation_count,
  // configuration writes
  input  logic                       cfg_we,
  input  logic [lcu_pkg::CFG_IW-1:0] cfg_index,
  input  logic [lcu_pkg::CFG_DW-1:0] cfg_wdata
);
  import lcu_pkg::*;

  localparam int          CELLS   = MAX_ROWS * MAX_COLS;
  localparam int          AW      = $clog2(CELLS);
  localparam int          KDIM    = 2 * KERNEL_RADIUS + 1;
  localparam int          KN      = KDIM * KDIM;
  localparam int          KIW     = $clog2(KN);
  localparam int          KCW     = $clog2(KDIM);
  localparam int          SW      = $clog2(KERNEL_RADIUS + 1);
  localparam int          KCenter = KN / 2;
  localparam logic [63:0] ExpStep = (64'd8 << 32) / EXP_TABLE_DEPTH;
  localparam logic [63:0] ExpC    = exp_ratio(ExpStep);

  // ring-kernel weight at a given offset
  function automatic logic [16:0] kernel_weight(int dr, int dc);
    logic [63:0] d2;
    logic [63:0] s;
    logic [63:0] dd;
    logic [63:0] u;
    longint      n;
    longint      d;
    d2 = 64'(dr * dr + dc * dc);
    s  = isqrt64(d2 << 32);
    n  = longint'(s / KERNEL_RADIUS);
    d  = n - 64'sd32768;
    dd = 64'(d * d);
    u  = (dd * 64'd200 / 64'd9) >> 16;
    return exp_lookup_c(u, EXP_TABLE_DEPTH, ExpC);
  endfunction

  function automatic logic [63:0] kernel_sum();
    logic [63:0] sum;
    sum = 64'd0;
    for (int r = -KERNEL_RADIUS; r <= KERNEL_RADIUS; r++) begin
      for (int c = -KERNEL_RADIUS; c <= KERNEL_RADIUS; c++) begin
        sum = sum + 64'(kernel_weight(r, c));
      end
    end
    return sum;
  endfunction

  localparam logic [63:0] KTotal = kernel_sum();
  localparam int          KW     = $clog2(KTotal + 64'd1);
  localparam int          ACC_W  = KW + 16;

  function automatic logic [AW-1:0] cell_addr(logic [6:0] r, logic [6:0] c);
    return AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
  endfunction

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SETUP, S_SCAN, S_DRAIN, S_GROW, S_READ, S_EMIT
  } state_t;

  // configuration registers
  logic [6:0]  rows_r, cols_r;
  logic [15:0] mu_r, dt_r, thr_r;
  logic [19:0] ivs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RST_ROWS;
      cols_r <= RST_COLS;
      mu_r   <= RST_MU;
      ivs_r  <= RST_IVS;
      dt_r   <= RST_DT;
      thr_r  <= RST_THR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: rows_r <= cfg_wdata[6:0];
        CFG_COLS: cols_r <= cfg_wdata[6:0];
        CFG_MU:   mu_r   <= cfg_wdata[15:0];
        CFG_IVS:  ivs_r  <= cfg_wdata;
        CFG_DT:   dt_r   <= cfg_wdata[15:0];
        CFG_THR:  thr_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // effective grid size: zero acts as one, clipped to the built size
  logic [6:0] nrows, ncols;
  always_comb begin
    nrows = (rows_r == 7'd0) ? 7'd1 : ((9'(rows_r) > 9'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_r);
    ncols = (cols_r == 7'd0) ? 7'd1 : ((9'(cols_r) > 9'(MAX_COLS)) ? 7'(MAX_COLS) : cols_r);
  end

  // kernel weight rom
  logic [16:0] kern_rom [KN];
  for (genvar gr = 0; gr < KDIM; gr++) begin : g_kr
    for (genvar gc = 0; gc < KDIM; gc++) begin : g_kc
      assign kern_rom[gr*KDIM+gc] = kernel_weight(gr - KERNEL_RADIUS, gc - KERNEL_RADIUS);
    end
  end

  state_t            state_r;
  logic [1:0]        mode_r;
  logic [5:0]        r_r, c_r;
  logic [CELL_W-1:0] load_r;
  logic              bank_r;
  logic [GEN_W-1:0]  gen_r;
  logic [AW-1:0]     clr_r;
  logic [6:0]        nr_r, nc_r, nc0_r;
  logic [SW-1:0]     sc_r;
  logic [KIW-1:0]    kidx_r;
  logic [KCW-1:0]    wcol_r;
  logic [CELL_W-1:0] res_v_r;
  logic              res_commit_r;
  logic              out_valid_r;
  logic              emit_fire;

  // scan pipeline
  logic              rd_v_r, ctr_r, prod_v_r;
  logic [16:0]       w_r;
  logic [32:0]       prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [CELL_W-1:0] v0_r;

  // growth unit
  logic              grow_start, grow_done;
  logic [CELL_W-1:0] grow_res;

  // memory ports
  logic              we_live, we_other, we0, we1;
  logic [AW-1:0]     addr_live, addr_other, addr0, addr1;
  logic [CELL_W-1:0] wd_live, wd_other, wd0, wd1, rd0, rd1, rd_live;

  logic [AW-1:0] here_addr;
  logic [6:0]    nr_dec, nc_dec, nr_inc, nc_inc;

  assign here_addr = cell_addr({1'b0, r_r}, {1'b0, c_r});
  assign nr_dec    = (nr_r == 7'd0) ? nrows - 7'd1 : nr_r - 7'd1;
  assign nc_dec    = (nc_r == 7'd0) ? ncols - 7'd1 : nc_r - 7'd1;
  assign nr_inc    = (nr_r + 7'd1 == nrows) ? 7'd0 : nr_r + 7'd1;
  assign nc_inc    = (nc_r + 7'd1 == ncols) ? 7'd0 : nc_r + 7'd1;
  assign rd_live   = bank_r ? rd1 : rd0;

  assign grow_start = (state_r == S_DRAIN) && !rd_v_r && !prod_v_r;

  // live bank takes loads, reads and the scan; the other bank takes updates
  always_comb begin
    we_live    = 1'b0;
    addr_live  = here_addr;
    wd_live    = load_r;
    we_other   = 1'b0;
    addr_other = here_addr;
    wd_other   = grow_res;
    case (state_r)
      S_DISPATCH: we_live = (mode_t'(mode_r) == MODE_LOAD);
      S_SCAN:     addr_live = cell_addr(nr_r, nc_r);
      S_GROW:     we_other = grow_done;
      default: ;
    endcase
    if (state_r == S_CLEAR) begin
      we0 = 1'b1;  addr0 = clr_r;  wd0 = '0;
      we1 = 1'b1;  addr1 = clr_r;  wd1 = '0;
    end else if (bank_r) begin
      we1 = we_live;  addr1 = addr_live;  wd1 = wd_live;
      we0 = we_other; addr0 = addr_other; wd0 = wd_other;
    end else begin
      we0 = we_live;  addr0 = addr_live;  wd0 = wd_live;
      we1 = we_other; addr1 = addr_other; wd1 = wd_other;
    end
  end

  lcu_ram #(.DEPTH(CELLS)) u_bank0 (
    .clk(clk), .we(we0), .addr(addr0), .wdata(wd0), .rdata(rd0)
  );

  lcu_ram #(.DEPTH(CELLS)) u_bank1 (
    .clk(clk), .we(we1), .addr(addr1), .wdata(wd1), .rdata(rd1)
  );

  lcu_growth #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
    .ACC_W(ACC_W),
    .K_TOTAL(KTotal)
  ) u_growth (
    .clk(clk),
    .rst_n(rst_n),
    .start(grow_start),
    .acc(acc_r),
    .center_value(v0_r),
    .mu(mu_r),
    .ivs(ivs_r),
    .dt(dt_r),
    .done(grow_done),
    .result(grow_res)
  );

  // weighted sum: weight and read data are both registered at issue, so they line up in the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= (state_r == S_SCAN);
      prod_v_r <= rd_v_r;
    end
    w_r    <= kern_rom[kidx_r];
    ctr_r  <= (kidx_r == KIW'(KCenter));
    prod_r <= 33'(w_r) * 33'(rd_live);
    if (rd_v_r && ctr_r) v0_r <= rd_live;
    if (state_r == S_DISPATCH) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // result shaping
  logic [23:0] age_prod;
  logic        res_alive;
  assign res_alive = !res_commit_r && (res_v_r > thr_r);
  assign age_prod  = {res_v_r, 8'd0} - {8'd0, res_v_r};

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;

  // a result is registered once the output slot is free or being taken
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      bank_r      <= 1'b0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CELLS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            r_r     <= umod6(in_row, nrows);
            c_r     <= umod6(in_col, ncols);
            load_r  <= in_load_value;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_commit_r <= 1'b0;
          unique case (mode_t'(mode_r))
            MODE_LOAD: begin
              res_v_r <= load_r;
              state_r <= S_EMIT;
            end
            MODE_UPDATE: begin
              nr_r    <= {1'b0, r_r};
              nc_r    <= {1'b0, c_r};
              sc_r    <= SW'(KERNEL_RADIUS);
              state_r <= S_SETUP;
            end
            MODE_COMMIT: begin
              bank_r       <= ~bank_r;
              gen_r        <= gen_r + GEN_W'(1);
              res_v_r      <= '0;
              res_commit_r <= 1'b1;
              state_r      <= S_EMIT;
            end
            MODE_READ: state_r <= S_READ;
          endcase
        end
        S_SETUP: begin
          // step back to the top-left corner of the window with wrap
          nr_r   <= nr_dec;
          nc_r   <= nc_dec;
          nc0_r  <= nc_dec;
          sc_r   <= sc_r - SW'(1);
          kidx_r <= '0;
          wcol_r <= '0;
          if (sc_r == SW'(1)) state_r <= S_SCAN;
        end
        S_SCAN: begin
          kidx_r <= kidx_r + KIW'(1);
          if (wcol_r == KCW'(KDIM - 1)) begin
            wcol_r <= '0;
            nc_r   <= nc0_r;
            nr_r   <= nr_inc;
          end else begin
            wcol_r <= wcol_r + KCW'(1);
            nc_r   <= nc_inc;
          end
          if (kidx_r == KIW'(KN - 1)) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (grow_start) state_r <= S_GROW;
        end
        S_GROW: begin
          if (grow_done) begin
            res_v_r <= grow_res;
            state_r <= S_EMIT;
          end
        end
        S_READ: begin
          res_v_r <= rd_live;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_cell_value       <= res_v_r;
            out_alive            <= res_alive;
            out_age              <= res_alive ? age_prod[23:16] : 8'd0;
            out_generation_count <= gen_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/tb_lenia_cell_update.sv */
// testbench for the lenia cell update engine: directed, config sweep, random and stall tests
`timescale 1ns / 1ps

module tb_lenia_cell_update;
  import lcu_pkg::*;

  localparam int GRID     = 64;
  localparam int RAD      = 5;
  localparam int KD       = 2 * RAD + 1;
  localparam int EDEPTH   = 256;
  localparam int STALL_LIMIT = 20000;  // cycles with no transaction before giving up

  typedef struct {
    logic [15:0] cell_value;
    logic        alive;
    logic [7:0]  age;
    logic [31:0] gen;
  } cell_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_mode;
  logic [5:0] in_row;
  logic [5:0] in_col;
  logic [CELL_W-1:0] in_load_value;
  logic out_valid;
  logic out_ready;
  logic [CELL_W-1:0] out_cell_value;
  logic out_alive;
  logic [7:0] out_age;
  logic [GEN_W-1:0] out_generation_count;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  lenia_cell_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_row(in_row),
    .in_col(in_col), .in_load_value(in_load_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_cell_value(out_cell_value),
    .out_alive(out_alive), .out_age(out_age), .out_generation_count(out_generation_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // mirror of the block state
  logic [15:0] field_mem [0:1][0:GRID*GRID-1];
  logic        live_bank;
  logic [31:0] gen_count;
  logic [6:0]  rows_r, cols_r;
  logic [15:0] mu_r, dt_r, thr_r;
  logic [19:0] ivs_r;

  // growth tables
  logic [31:0] exp_tab [0:EDEPTH-1];
  logic [31:0] ring_w [0:KD*KD-1];
  logic [63:0] ring_total;

  cell_result_t pending_q[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;       // receiver hold-off request, loaded by the receiver process
  int hold_left;
  int quiet_cycles;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, b, rem;
    root = 0;
    b = 64'd1 << 62;
    rem = v;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] exp_of(logic [63:0] u);
    logic [63:0] i;
    if (u >= (64'd1 << 40)) return 0;
    i = (u * EDEPTH) >> 19;
    if (i >= EDEPTH) return 0;
    return exp_tab[i];
  endfunction

  task automatic build_tables();
    logic [63:0] step, term, ratio, acc;
    longint n, d;
    logic [63:0] dd, u;
    int k;
    step = (64'd8 << 32) / EDEPTH;
    term = 64'd1 << 32;
    ratio = 64'd1 << 32;
    for (int j = 1; j <= 8; j++) begin
      term = ((term * step) >> 32) / j;
      if (j & 1) ratio = ratio - term;
      else ratio = ratio + term;
    end
    acc = 64'd1 << 32;
    for (int i = 0; i < EDEPTH; i++) begin
      exp_tab[i] = 32'((acc + 64'd32768) >> 16);
      acc = (acc * ratio) >> 32;
    end
    ring_total = 0;
    k = 0;
    for (int dr = -RAD; dr <= RAD; dr++) begin
      for (int dc = -RAD; dc <= RAD; dc++) begin
        n = longint'(int_sqrt(64'(dr * dr + dc * dc) << 32) / RAD);
        d = n - 32768;
        dd = 64'(d * d);
        u = (dd * 200 / 9) >> 16;
        ring_w[k] = exp_of(u);
        ring_total += ring_w[k];
        k++;
      end
    end
  endtask

  function automatic int eff(logic [6:0] v);
    if (v == 0) return 1;
    return (v > GRID) ? GRID : int'(v);
  endfunction

  function automatic logic [15:0] grow_cell(int r, int c, int nr, int nc);
    logic [63:0] acc, p, dd, u, mag;
    longint diff, g, nv;
    int k, rr, cc;
    acc = 0;
    k = 0;
    for (int dr = -RAD; dr <= RAD; dr++) begin
      for (int dc = -RAD; dc <= RAD; dc++) begin
        rr = (r + nr * 16 + dr) % nr;
        cc = (c + nc * 16 + dc) % nc;
        acc += 64'(ring_w[k]) * field_mem[live_bank][rr * GRID + cc];
        k++;
      end
    end
    p = ring_total != 0 ? acc / ring_total : 0;
    diff = longint'(p) - longint'(mu_r);
    dd = 64'(diff * diff);
    u = (dd * ivs_r) >> 21;
    g = 2 * longint'(exp_of(u)) - 65536;
    mag = (64'(g < 0 ? -g : g) * dt_r) >> 16;
    nv = longint'(field_mem[live_bank][r * GRID + c]) + (g < 0 ? -longint'(mag) : longint'(mag));
    if (nv < 0) nv = 0;
    if (nv > 65535) nv = 65535;
    return 16'(nv);
  endfunction

  // work out the result of one accepted transaction and advance the mirror
  task automatic predict_cell(logic [1:0] m, logic [5:0] row, logic [5:0] col, logic [15:0] lv);
    cell_result_t res;
    int nr, nc, r, c;
    logic [15:0] v;
    nr = eff(rows_r);
    nc = eff(cols_r);
    r = int'(row) % nr;
    c = int'(col) % nc;
    v = 0;
    case (mode_t'(m))
      MODE_LOAD: begin
        v = lv;
        field_mem[live_bank][r * GRID + c] = v;
      end
      MODE_UPDATE: begin
        v = grow_cell(r, c, nr, nc);
        field_mem[~live_bank][r * GRID + c] = v;
      end
      MODE_COMMIT: begin
        live_bank = ~live_bank;
        gen_count = gen_count + 1;
      end
      default: v = field_mem[live_bank][r * GRID + c];
    endcase
    res.cell_value = v;
    res.alive = (mode_t'(m) != MODE_COMMIT) && (v > thr_r);
    res.age = res.alive ? 8'((32'(v) * 255) >> 16) : 8'd0;
    res.gen = gen_count;
    pending_q.push_back(res);
  endtask

  // offer one transaction; valid stays high across back-to-back sends
  task automatic send_cell(logic [1:0] m, logic [5:0] row, logic [5:0] col, logic [15:0] lv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_row <= row;
    in_col <= col;
    in_load_value <= lv;
    do @(posedge clk); while (!in_ready);
    predict_cell(m, row, col, lv);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROWS: rows_r = val[6:0];
      CFG_COLS: cols_r = val[6:0];
      CFG_MU:   mu_r = val[15:0];
      CFG_IVS:  ivs_r = val;
      CFG_DT:   dt_r = val[15:0];
      CFG_THR:  thr_r = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [6:0] r, logic [6:0] c, logic [15:0] mu, logic [19:0] ivs,
                         logic [15:0] dt, logic [15:0] thr);
    write_reg(CFG_ROWS, 20'(r));
    write_reg(CFG_COLS, 20'(c));
    write_reg(CFG_MU, 20'(mu));
    write_reg(CFG_IVS, ivs);
    write_reg(CFG_DT, 20'(dt));
    write_reg(CFG_THR, 20'(thr));
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(20000, 0));
      default: return 16'($urandom);
    endcase
  endfunction

  // extremes of every field, every mode, reads of untouched cells, wrap and commit
  task automatic test_directed();
    send_cell(MODE_READ, 6'd0, 6'd0, 16'd0);
    send_cell(MODE_LOAD, 6'd0, 6'd0, 16'hFFFF);
    send_cell(MODE_LOAD, 6'd63, 6'd63, 16'd0);
    send_cell(MODE_LOAD, 6'd63, 6'd0, 16'd6555);
    send_cell(MODE_LOAD, 6'd1, 6'd62, 16'd6554);
    send_cell(MODE_LOAD, 6'd2, 6'd2, 16'hAAAA);
    send_cell(MODE_LOAD, 6'd3, 6'd4, 16'h5555);
    send_cell(MODE_READ, 6'd0, 6'd0, 16'hFFFF);
    send_cell(MODE_READ, 6'd63, 6'd0, 16'd0);
    send_cell(MODE_UPDATE, 6'd0, 6'd0, 16'd0);
    send_cell(MODE_UPDATE, 6'd63, 6'd63, 16'h1234);
    send_cell(MODE_UPDATE, 6'd20, 6'd40, 16'd0);
    send_cell(MODE_COMMIT, 6'd5, 6'd7, 16'hFFFF);
    send_cell(MODE_READ, 6'd0, 6'd0, 16'd0);
    send_cell(MODE_UPDATE, 6'd0, 6'd1, 16'd0);
    send_cell(MODE_COMMIT, 6'd0, 6'd0, 16'd0);
    send_cell(MODE_READ, 6'd1, 6'd62, 16'd0);
    drain_results();
  endtask

  // every register at its extremes, out-of-range row and column counts included
  task automatic test_config_sweep();
    set_all(7'd0, 7'd127, 16'd0, 20'hFFFFF, 16'hFFFF, 16'd0);
    send_cell(MODE_LOAD, 6'd63, 6'd63, 16'd40000);
    send_cell(MODE_UPDATE, 6'd17, 6'd45, 16'd0);
    send_cell(MODE_READ, 6'd33, 6'd9, 16'd0);
    drain_results();
    set_all(7'd1, 7'd1, 16'hFFFF, 20'd0, 16'd0, 16'hFFFF);
    send_cell(MODE_LOAD, 6'd5, 6'd5, 16'hFFFF);
    send_cell(MODE_UPDATE, 6'd63, 6'd0, 16'd0);
    send_cell(MODE_READ, 6'd0, 6'd63, 16'd0);
    drain_results();
    set_all(7'd127, 7'd0, 16'd30000, 20'd16, 16'hFFFF, 16'd100);
    send_cell(MODE_UPDATE, 6'd3, 6'd3, 16'd0);
    send_cell(MODE_LOAD, 6'd62, 6'd61, 16'd1);
    send_cell(MODE_UPDATE, 6'd62, 6'd61, 16'd0);
    drain_results();
  endtask

  // mostly load/update/read traffic with occasional commits on a random grid size
  task automatic test_random(int count);
    logic [1:0] m;
    int pick;
    drain_results();
    set_all(7'($urandom_range(64, 5)), 7'($urandom_range(64, 5)), 16'($urandom_range(20000)),
            20'($urandom_range(300000)), 16'($urandom), 16'($urandom));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) m = MODE_LOAD;
      else if (pick < 70) m = MODE_UPDATE;
      else if (pick < 92) m = MODE_READ;
      else m = MODE_COMMIT;
      send_cell(m, 6'($urandom), 6'($urandom), pick_value());
    end
    drain_results();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_req = 600;
    for (int i = 0; i < 8; i++)
      send_cell(i[0] ? MODE_READ : MODE_LOAD, 6'($urandom), 6'($urandom), 16'($urandom));
    drain_results();
  endtask

  // receiver: random idling plus requested hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    cell_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value %h gen %0d", $time, out_cell_value,
                 out_generation_count);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_cell_value !== exp_r.cell_value) begin
          $display("%0t: cell_value expected %h actual %h", $time, exp_r.cell_value,
                   out_cell_value);
          errors++;
        end
        if (out_alive !== exp_r.alive) begin
          $display("%0t: alive expected %b actual %b", $time, exp_r.alive, out_alive);
          errors++;
        end
        if (out_age !== exp_r.age) begin
          $display("%0t: age expected %0d actual %0d", $time, exp_r.age, out_age);
          errors++;
        end
        if (out_generation_count !== exp_r.gen) begin
          $display("%0t: generation_count expected %0d actual %0d", $time, exp_r.gen,
                   out_generation_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    errors = 0;
    hold_req = 0;
    hold_left = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_LOAD;
    in_row = 0;
    in_col = 0;
    in_load_value = 0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 0;
    cfg_wdata = 0;
    build_tables();
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < GRID * GRID; i++) field_mem[b][i] = 0;
    live_bank = 0;
    gen_count = 0;
    rows_r = RST_ROWS;
    cols_r = RST_COLS;
    mu_r = RST_MU;
    ivs_r = RST_IVS;
    dt_r = RST_DT;
    thr_r = RST_THR;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 18;
    recv_idle_pct = 83;
    test_directed();
    test_config_sweep();
    test_random(300);
    test_backpressure();
    // swap the idling
    send_idle_pct = 83;
    recv_idle_pct = 18;
    test_random(300);
    test_backpressure();
    // no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(300);

    drain_results();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
